@@ design/mpu_rac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpu_rac_pkg
// Types and constants shared by the region access check block.
// ----------------------------------------------------------------------------
package mpu_rac_pkg;

    // Region storage and field widths
    localparam int unsigned STORED_REGIONS = 8;
    localparam int unsigned HIT_W          = 3;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned TAG_W          = 5;
    localparam int unsigned PADDR_W        = 6;
    localparam int unsigned PDATA_W        = 64;
    localparam int unsigned PAIRS          = 4;

    // Size tag special values
    localparam logic [TAG_W-1:0] TAG_ALL = 5'd31;
    localparam logic [TAG_W-1:0] TAG_MIN = 5'd11;

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_PERMS       = 3'd1,
        REG_CACHEABLE   = 3'd2,
        REG_FORCE_CACHE = 3'd3,
        REG_PAIR0       = 3'd4,
        REG_PAIR1       = 3'd5,
        REG_PAIR2       = 3'd6,
        REG_PAIR3       = 3'd7
    } reg_idx_t;

    // Access permission codes of a region
    typedef enum logic [1:0] {
        AP_NONE         = 2'd0,
        AP_PRIV         = 2'd1,
        AP_PRIV_OR_READ = 2'd2,
        AP_FULL         = 2'd3
    } ap_t;

    // Configuration seen by the check logic
    typedef struct packed {
        logic                                  enable;
        logic [2*STORED_REGIONS-1:0]           access_perms;
        logic [STORED_REGIONS-1:0]             region_cacheable;
        logic                                  force_cacheable;
        logic [STORED_REGIONS-1:0][ADDR_W-1:0] region_word;
    } cfg_t;

endpackage
`default_nettype wire

@@ design/mpu_rac_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpu_rac_cfg
// APB register file holding unit enable, permissions and region words.
// ----------------------------------------------------------------------------
module mpu_rac_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mpu_rac_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mpu_rac_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mpu_rac_pkg::PDATA_W-1:0]   prdata,
    output logic                                   pready,
    output mpu_rac_pkg::cfg_t                      cfg
);

    logic                                         enable_reg;
    logic [2*mpu_rac_pkg::STORED_REGIONS-1:0]     perms_reg;
    logic [mpu_rac_pkg::STORED_REGIONS-1:0]       cacheable_reg;
    logic                                         force_reg;
    logic [mpu_rac_pkg::PAIRS-1:0][mpu_rac_pkg::PDATA_W-1:0] pair_reg;

    mpu_rac_pkg::reg_idx_t idx;
    logic                  wr_en;

    assign pready = 1'b1;
    assign idx    = mpu_rac_pkg::reg_idx_t'(paddr[mpu_rac_pkg::PADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the addressed register on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            perms_reg     <= '0;
            cacheable_reg <= '0;
            force_reg     <= 1'b1;
            pair_reg      <= '0;
        end else if (wr_en) begin
            case (idx)
                mpu_rac_pkg::REG_ENABLE:      enable_reg    <= pwdata[0];
                mpu_rac_pkg::REG_PERMS:       perms_reg     <= pwdata[15:0];
                mpu_rac_pkg::REG_CACHEABLE:   cacheable_reg <= pwdata[7:0];
                mpu_rac_pkg::REG_FORCE_CACHE: force_reg     <= pwdata[0];
                mpu_rac_pkg::REG_PAIR0:       pair_reg[0]   <= pwdata;
                mpu_rac_pkg::REG_PAIR1:       pair_reg[1]   <= pwdata;
                mpu_rac_pkg::REG_PAIR2:       pair_reg[2]   <= pwdata;
                mpu_rac_pkg::REG_PAIR3:       pair_reg[3]   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        case (idx)
            mpu_rac_pkg::REG_ENABLE:      prdata = {63'd0, enable_reg};
            mpu_rac_pkg::REG_PERMS:       prdata = {48'd0, perms_reg};
            mpu_rac_pkg::REG_CACHEABLE:   prdata = {56'd0, cacheable_reg};
            mpu_rac_pkg::REG_FORCE_CACHE: prdata = {63'd0, force_reg};
            mpu_rac_pkg::REG_PAIR0:       prdata = pair_reg[0];
            mpu_rac_pkg::REG_PAIR1:       prdata = pair_reg[1];
            mpu_rac_pkg::REG_PAIR2:       prdata = pair_reg[2];
            mpu_rac_pkg::REG_PAIR3:       prdata = pair_reg[3];
            default:                      prdata = '0;
        endcase
    end

    // Split each pair into its two region words
    always_comb begin
        cfg.enable           = enable_reg;
        cfg.access_perms     = perms_reg;
        cfg.region_cacheable = cacheable_reg;
        cfg.force_cacheable  = force_reg;
        for (int n = 0; n < mpu_rac_pkg::PAIRS; n++) begin
            cfg.region_word[2*n]   = pair_reg[n][31:0];
            cfg.region_word[2*n+1] = pair_reg[n][63:32];
        end
    end

endmodule
`default_nettype wire

@@ design/mpu_rac_match.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpu_rac_match
// Region compare, highest-region priority pick and permission decode.
// ----------------------------------------------------------------------------
module mpu_rac_match #(
    parameter int unsigned CHECKED = 8
) (
    input  wire mpu_rac_pkg::cfg_t               cfg,
    input  wire logic [mpu_rac_pkg::ADDR_W-1:0]  address,
    input  wire logic                            privileged,
    input  wire logic                            is_write,
    output logic                                 permitted,
    output logic                                 cacheable
);

    logic [mpu_rac_pkg::STORED_REGIONS-1:0] hits;
    logic [mpu_rac_pkg::HIT_W-1:0]          hit;
    logic                                   found;
    mpu_rac_pkg::ap_t                       ap;
    logic                                   flag;

    // Compare the address with each checked region
    always_comb begin
        logic [mpu_rac_pkg::TAG_W-1:0]  tag;
        logic [mpu_rac_pkg::TAG_W-1:0]  shamt;
        logic [mpu_rac_pkg::ADDR_W-1:0] mask;
        hits = '0;
        for (int n = 0; n < mpu_rac_pkg::STORED_REGIONS; n++) begin
            tag   = cfg.region_word[n][5:1];
            // small regions are rounded up to one 4 KB page
            shamt = (tag < mpu_rac_pkg::TAG_MIN) ? mpu_rac_pkg::TAG_MIN + 5'd1
                                                 : tag + 5'd1;
            mask  = 32'hffff_ffff << shamt;
            if (n < CHECKED && cfg.region_word[n][0]) begin
                hits[n] = (tag == mpu_rac_pkg::TAG_ALL) ||
                          ((address & mask) == (cfg.region_word[n] & mask));
            end
        end
    end

    // Pick the highest-numbered matching region
    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int n = 0; n < mpu_rac_pkg::STORED_REGIONS; n++) begin
            if (hits[n]) begin
                found = 1'b1;
                hit   = mpu_rac_pkg::HIT_W'(n);
            end
        end
    end

    assign ap   = mpu_rac_pkg::ap_t'(cfg.access_perms[{hit, 1'b0} +: 2]);
    assign flag = cfg.force_cacheable || cfg.region_cacheable[hit];

    // Decode the permission code of the winning region
    always_comb begin
        permitted = 1'b0;
        cacheable = 1'b0;
        if (!cfg.enable) begin
            permitted = 1'b1;
        end else if (found) begin
            case (ap)
                mpu_rac_pkg::AP_NONE: begin
                    permitted = 1'b0;
                    cacheable = 1'b0;
                end
                mpu_rac_pkg::AP_PRIV: begin
                    permitted = privileged;
                    cacheable = flag;
                end
                mpu_rac_pkg::AP_PRIV_OR_READ: begin
                    permitted = privileged || !is_write;
                    cacheable = flag;
                end
                mpu_rac_pkg::AP_FULL: begin
                    permitted = 1'b1;
                    cacheable = flag;
                end
                default: begin
                    permitted = 1'b0;
                    cacheable = 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/mpu_region_access_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The request is registered on acceptance and the decision, after one pass of
// region compare and decode, is registered when the result stage is empty or
// draining.
// Throughput: one request per cycle; the input stage keeps taking requests
// while a result waits, stalling only when both stages are full.
// Reset: synchronous, active low; clears both stage valids and the configuration
// registers, force_cacheable comes up set and the unit comes up disabled.
// ----------------------------------------------------------------------------
// mpu_region_access_check
// Checks one access address against the protection regions per cycle unless both stages are full.
// ----------------------------------------------------------------------------
module mpu_region_access_check #(
    parameter int unsigned REGIONS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // [31:0] address
    input  wire logic [1:0]                        s_tuser,  // [0] privileged, [1] is_write
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [7:0]                        m_tdata,  // [0] permitted, [1] cacheable
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mpu_rac_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mpu_rac_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mpu_rac_pkg::PDATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int unsigned CHECKED =
        (REGIONS < mpu_rac_pkg::STORED_REGIONS) ? REGIONS : mpu_rac_pkg::STORED_REGIONS;

    mpu_rac_pkg::cfg_t cfg;

    logic        in_valid_reg;
    logic [31:0] addr_reg;
    logic        priv_reg;
    logic        wr_reg;
    logic        m_valid_reg;
    logic        perm_reg;
    logic        cache_reg;
    logic        perm_next;
    logic        cache_next;
    logic        advance;
    logic        s_take;

    mpu_rac_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpu_rac_match #(
        .CHECKED (CHECKED)
    ) u_match (
        .cfg        (cfg),
        .address    (addr_reg),
        .privileged (priv_reg),
        .is_write   (wr_reg),
        .permitted  (perm_next),
        .cacheable  (cache_next)
    );

    // Move a request on when the result stage is empty or draining
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    // Hold the accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            addr_reg <= s_tdata;
            priv_reg <= s_tuser[0];
            wr_reg   <= s_tuser[1];
        end
    end

    // Capture the decision, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            perm_reg  <= perm_next;
            cache_reg <= cache_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, cache_reg, perm_reg};

`ifndef ASSERT_OFF
    // A stalled request side means both stages are full and the result is held
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
        else $error("request stalled without a full pipeline");

    // A disabled unit permits the access and never reports cacheable
    a_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !cfg.enable) |=> (m_tdata[0] && !m_tdata[1]))
        else $error("disabled unit gave a restricted result");

    // An advancing request always yields a valid result next cycle
    a_advance_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced request lost");

    // A result still waiting stays valid
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending result dropped");
`endif

endmodule
`default_nettype wire
